// File: rtl/iirbp_pkg.sv
// shared constants, request and register codes, and controller/datapath link types
// for the band-pass beam filter; no dependencies
`default_nettype none

package iirbp_pkg;

    localparam int FILTER_ORDER = 2;
    localparam int HIST_TAPS    = 2 * FILTER_ORDER;
    localparam int FF_TAPS      = 2 * FILTER_ORDER + 1;
    localparam int ALL_TAPS     = FF_TAPS + HIST_TAPS;

    localparam int TAP_W      = $clog2(ALL_TAPS);
    localparam int FF_IDX_W   = $clog2(FF_TAPS);
    localparam int HIST_IDX_W = $clog2(HIST_TAPS);

    localparam int REQ_W      = 2;
    localparam int COEF_IDX_W = 5;
    localparam int COEF_W     = 32;
    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 32;
    localparam int ACC_W      = 64;
    localparam int GAIN_W     = 32;
    localparam int POS_W      = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 32;

    // request kinds carried in tuser
    localparam logic [REQ_W-1:0] REQ_SAMPLE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD_FF = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOAD_FB = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_GAIN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAM_LENGTH = 1'd1;

    localparam logic [GAIN_W-1:0] SCALE_GAIN_RST  = 32'hFFFF_FFFF;
    localparam logic [POS_W-1:0]  BEAM_LENGTH_RST = 16'd2048;

    typedef struct packed {
        logic             start;
        logic             load_ff;
        logic             load_fb;
        logic             issue;
        logic [TAP_W-1:0] tap;
        logic             finish;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// File: rtl/iirbp_ctrl.sv
// sequencer for the beam filter: takes input words, walks the taps through the
// datapath, waits for the multiply pipe to drain and hands the result over; uses iirbp_pkg
`default_nettype none

module iirbp_ctrl (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  wire  [iirbp_pkg::REQ_W-1:0]  i_in_req,
    output logic                         o_in_ready,
    input  iirbp_pkg::t_dp_status        i_status,
    output iirbp_pkg::t_dp_cmd           o_cmd
);
    import iirbp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    t_state           r_state;
    logic [TAP_W-1:0] r_tap;
    logic             r_ready;
    logic             accept;

    assign accept     = i_in_valid && r_ready;
    assign o_in_ready = r_ready;

    always_comb begin
        o_cmd         = '0;
        o_cmd.tap     = r_tap;
        o_cmd.start   = accept && (i_in_req == REQ_SAMPLE);
        o_cmd.load_ff = accept && (i_in_req == REQ_LOAD_FF);
        o_cmd.load_fb = accept && (i_in_req == REQ_LOAD_FB);
        o_cmd.issue   = (r_state == ST_MAC);
        o_cmd.finish  = (r_state == ST_FINISH) && i_status.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tap   <= '0;
            r_ready <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_ready <= 1'b1;
                    if (accept && (i_in_req == REQ_SAMPLE)) begin
                        r_state <= ST_MAC;
                        r_tap   <= '0;
                        r_ready <= 1'b0;
                    end
                end
                ST_MAC: begin
                    if (r_tap == TAP_W'(ALL_TAPS - 1)) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_tap <= r_tap + TAP_W'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!i_status.pipe_busy) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (i_status.out_free) begin
                        r_state <= ST_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_ready <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/iirbp_datapath.sv
// datapath of the beam filter: registers, coefficient tables, histories,
// two-stage multiply pipe, accumulator, rounding and output register; uses iirbp_pkg
`default_nettype none

module iirbp_datapath (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  iirbp_pkg::t_dp_cmd                    i_cmd,
    output iirbp_pkg::t_dp_status                 o_status,
    input  wire  [iirbp_pkg::COEF_IDX_W-1:0]      i_coef_index,
    input  wire  signed [iirbp_pkg::COEF_W-1:0]   i_coef_value,
    input  wire  signed [iirbp_pkg::SAMPLE_W-1:0] i_sample,
    input  wire                                   i_cfg_we,
    input  wire  [iirbp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [iirbp_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  wire                                   i_out_ready,
    output logic                                  o_out_valid,
    output logic signed [iirbp_pkg::OUT_W-1:0]    o_filtered,
    output logic                                  o_beam_end
);
    import iirbp_pkg::*;

    logic [GAIN_W-1:0]          r_scale_gain;
    logic [POS_W-1:0]           r_beam_length;
    logic signed [COEF_W-1:0]   r_ff_table [FF_TAPS];
    logic signed [COEF_W-1:0]   r_fb_table [HIST_TAPS];
    logic signed [SAMPLE_W-1:0] r_in_hist  [HIST_TAPS];
    logic signed [OUT_W-1:0]    r_out_hist [HIST_TAPS];
    logic [POS_W-1:0]           r_pos;
    logic signed [SAMPLE_W-1:0] r_x;

    // multiply pipe
    logic                       r_v1;
    logic                       r_v2;
    logic                       r_s1_ff;
    logic signed [SAMPLE_W-1:0] r_s1_x;
    logic signed [63:0]         r_s1_prod;
    logic signed [ACC_W-1:0]    r_s2_term;
    logic signed [ACC_W-1:0]    r_acc;

    logic                       r_out_valid;
    logic signed [OUT_W-1:0]    r_out_data;
    logic                       r_out_last;

    // stage one operand selection
    logic [TAP_W-1:0]           hist_off;
    logic [TAP_W-1:0]           fb_off;
    logic signed [COEF_W:0]     s1_a;
    logic signed [COEF_W:0]     s1_b;
    logic signed [SAMPLE_W-1:0] s1_x;
    logic                       s1_ff;
    logic signed [2*COEF_W+1:0] s1_mult;

    logic signed [COEF_W-1:0]   s2_ce;
    logic signed [SAMPLE_W+COEF_W-1:0] s2_ff_prod;
    logic signed [ACC_W-1:0]    s2_term;

    logic signed [ACC_W-1:0]    rounded;
    logic signed [ACC_W-17:0]   y_wide;
    logic signed [OUT_W-1:0]    y_sat;
    logic [POS_W:0]             pos_inc;
    logic [POS_W:0]             beam_len;
    logic                       last;
    logic [COEF_IDX_W-1:0]      fb_wr;

    assign o_status.pipe_busy = r_v1 || r_v2;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_filtered         = r_out_data;
    assign o_beam_end         = r_out_last;

    always_comb begin
        hist_off = i_cmd.tap - TAP_W'(1);
        fb_off   = i_cmd.tap - TAP_W'(FF_TAPS);
        s1_x     = r_x;
        if (i_cmd.tap < TAP_W'(FF_TAPS)) begin
            s1_ff = 1'b1;
            s1_a  = {r_ff_table[i_cmd.tap[FF_IDX_W-1:0]][COEF_W-1],
                     r_ff_table[i_cmd.tap[FF_IDX_W-1:0]]};
            s1_b  = {1'b0, r_scale_gain};
            if (i_cmd.tap != '0) begin
                s1_x = r_in_hist[hist_off[HIST_IDX_W-1:0]];
            end
        end else begin
            s1_ff = 1'b0;
            s1_a  = {r_out_hist[fb_off[HIST_IDX_W-1:0]][OUT_W-1],
                     r_out_hist[fb_off[HIST_IDX_W-1:0]]};
            s1_b  = {r_fb_table[fb_off[HIST_IDX_W-1:0]][COEF_W-1],
                     r_fb_table[fb_off[HIST_IDX_W-1:0]]};
        end
    end

    assign s1_mult = s1_a * s1_b;

    // feedforward: effective coefficient is the top half of c * gain, times x
    // feedback: y * d scaled down by 2^8 and subtracted
    assign s2_ce      = r_s1_prod[63:32];
    assign s2_ff_prod = r_s1_x * s2_ce;
    assign s2_term    = r_s1_ff ? ACC_W'(s2_ff_prod) : -(r_s1_prod >>> 8);

    // round half up to q24.8 and saturate
    assign rounded = r_acc + ACC_W'(32768);
    assign y_wide  = rounded[ACC_W-1:16];
    always_comb begin
        if (y_wide[ACC_W-17:OUT_W-1] == '0 || y_wide[ACC_W-17:OUT_W-1] == '1) begin
            y_sat = y_wide[OUT_W-1:0];
        end else if (y_wide[ACC_W-17]) begin
            y_sat = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    // zero length means a full 65536-sample beam
    assign pos_inc  = {1'b0, r_pos} + (POS_W+1)'(1);
    assign beam_len = (r_beam_length == '0) ? {1'b1, {POS_W{1'b0}}} : {1'b0, r_beam_length};
    assign last     = pos_inc >= beam_len;
    assign fb_wr    = i_coef_index - COEF_IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_gain  <= SCALE_GAIN_RST;
            r_beam_length <= BEAM_LENGTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCALE_GAIN:  r_scale_gain  <= i_cfg_wdata[GAIN_W-1:0];
                CFG_BEAM_LENGTH: r_beam_length <= i_cfg_wdata[POS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FF_TAPS; i++) begin
                r_ff_table[i] <= '0;
            end
            for (int i = 0; i < HIST_TAPS; i++) begin
                r_fb_table[i] <= '0;
            end
        end else begin
            if (i_cmd.load_ff && (i_coef_index < COEF_IDX_W'(FF_TAPS))) begin
                r_ff_table[i_coef_index[FF_IDX_W-1:0]] <= i_coef_value;
            end
            if (i_cmd.load_fb && (i_coef_index != '0)
                    && (i_coef_index <= COEF_IDX_W'(HIST_TAPS))) begin
                r_fb_table[fb_wr[HIST_IDX_W-1:0]] <= i_coef_value;
            end
        end
    end

    // histories and beam position move once per finished sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_TAPS; i++) begin
                r_in_hist[i]  <= '0;
                r_out_hist[i] <= '0;
            end
            r_pos <= '0;
        end else if (i_cmd.finish) begin
            if (last) begin
                for (int i = 0; i < HIST_TAPS; i++) begin
                    r_in_hist[i]  <= '0;
                    r_out_hist[i] <= '0;
                end
                r_pos <= '0;
            end else begin
                for (int i = HIST_TAPS - 1; i > 0; i--) begin
                    r_in_hist[i]  <= r_in_hist[i-1];
                    r_out_hist[i] <= r_out_hist[i-1];
                end
                r_in_hist[0]  <= r_x;
                r_out_hist[0] <= y_sat;
                r_pos         <= pos_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x <= i_sample;
        end
        r_s1_ff   <= s1_ff;
        r_s1_x    <= s1_x;
        r_s1_prod <= s1_mult[63:0];
        r_s2_term <= s2_term;
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + r_s2_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_data <= y_sat;
            r_out_last <= last;
        end
    end

endmodule

`default_nettype wire

// File: rtl/iir_bandpass_beam_filter_top.sv
// top level of the direct-form-I band-pass beam filter: stream ports, register
// write port, controller and datapath; uses iirbp_pkg, iirbp_ctrl, iirbp_datapath
//
//   port group   dir  width  contents
//   s_axis       in   56+2   tdata: coef_index, coef_value, sample; tuser: req_type
//   m_axis       out  32+1   tdata: filtered; tlast: beam_end
//   i_cfg        in   1+32   register index and write data
//
// a sample word is accepted, its taps are issued one per cycle on the shared
// 33x33 multiplier, the multiply pipe drains and the result is rounded and
// loaded into the output register
// coefficient loads are written into the tables on accept and give no output word
// a result waiting on m_axis does not block the next accept; only the final
// write of the following sample waits for the output register to free up
// synchronous active-low reset sets registers to their reset values and clears tables, histories and position
`default_nettype none

module iir_bandpass_beam_filter_top (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [4:0] coef_index, [36:5] coef_value, [52:37] sample, [55:53] zero
    input  wire  [iirbp_pkg::IN_DATA_W-1:0]         s_axis_tdata,
    // [1:0] req_type
    input  wire  [iirbp_pkg::REQ_W-1:0]             s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire                                     m_axis_tready,
    // [31:0] filtered
    output logic [iirbp_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    output logic                                    m_axis_tlast,
    input  wire                                     i_cfg_we,
    input  wire  [iirbp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire  [iirbp_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);
    import iirbp_pkg::*;

    t_dp_cmd                    w_cmd;
    t_dp_status                 w_status;
    logic signed [OUT_W-1:0]    w_filtered;

    iirbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_req   (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    iirbp_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_coef_index (s_axis_tdata[4:0]),
        .i_coef_value (s_axis_tdata[36:5]),
        .i_sample     (s_axis_tdata[52:37]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_filtered   (w_filtered),
        .o_beam_end   (m_axis_tlast)
    );

    assign m_axis_tdata = w_filtered;

    // no new word is taken while taps are being issued
    a_no_accept_during_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && w_cmd.issue))
        else $error("input ready while taps are issued");

    // the result is only written into a free output register
    a_finish_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> w_status.out_free)
        else $error("result written over a pending output word");

    a_finish_shows_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> m_axis_tvalid)
        else $error("finished sample not presented on output");

    // loads and unknown kinds keep the input side open
    a_load_stays_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser != REQ_SAMPLE))
        |=> s_axis_tready)
        else $error("non-sample word stalled the input");

endmodule

`default_nettype wire

// File: dv/testbench.sv
// self-checking testbench for iir_bandpass_beam_filter_top: directed and random
// coefficient loads, beams of samples and register writes; needs rtl/iirbp_pkg.sv
// and the top level with its controller and datapath
`timescale 1ns / 1ps

module testbench;
    import iirbp_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 11;
    localparam int SETTLE       = 24;     // longer than one sample word through the MAC
    localparam int STALL_LIMIT  = 2000;
    localparam int TARGET_WORDS = 2000;
    localparam int IDLE_PCT     = 11;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SAT_LO = -64'sh0000_0000_8000_0000;

    typedef struct {
        logic signed [OUT_W-1:0] filtered;
        logic                    beam_end;
    } t_filt_result;

    class beam_filter_scoreboard;
        logic [GAIN_W-1:0]          gain;
        logic [POS_W-1:0]           beam_len;
        logic [POS_W-1:0]           position;
        logic signed [SAMPLE_W-1:0] x_hist [HIST_TAPS];
        logic signed [OUT_W-1:0]    y_hist [HIST_TAPS];
        logic signed [COEF_W-1:0]   ff_coef [FF_TAPS];
        logic signed [COEF_W-1:0]   fb_coef [HIST_TAPS];
        t_filt_result               pending_outputs [$];
        int                         errors;

        function new();
            gain     = SCALE_GAIN_RST;
            beam_len = BEAM_LENGTH_RST;
            position = '0;
            errors   = 0;
            foreach (x_hist[i]) x_hist[i] = '0;
            foreach (y_hist[i]) y_hist[i] = '0;
            foreach (ff_coef[i]) ff_coef[i] = '0;
            foreach (fb_coef[i]) fb_coef[i] = '0;
        endfunction

        function int pending();
            return pending_outputs.size();
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SCALE_GAIN:  gain = data[GAIN_W-1:0];
                CFG_BEAM_LENGTH: beam_len = data[POS_W-1:0];
                default: ;
            endcase
        endfunction

        // one direct-form-I step, histories shift or clear at the beam end
        function t_filt_result filter_sample(logic signed [SAMPLE_W-1:0] x);
            longint       acc, xv, cf, g, yv, dv, y;
            int           span;
            logic         last;
            t_filt_result r;
            acc = 0;
            g   = gain;
            for (int i = 0; i < FF_TAPS; i++) begin
                if (i == 0) xv = x;
                else xv = x_hist[i-1];
                cf = ff_coef[i];
                acc += xv * ((cf * g) >>> 32);
            end
            for (int i = 0; i < HIST_TAPS; i++) begin
                yv = y_hist[i];
                dv = fb_coef[i];
                acc -= (yv * dv) >>> 8;
            end
            y = (acc + 32768) >>> 16;
            if (y > SAT_HI) y = SAT_HI;
            if (y < SAT_LO) y = SAT_LO;
            span = (beam_len == 0) ? 65536 : int'(beam_len);
            last = (int'(position) + 1) >= span;
            if (last) begin
                foreach (x_hist[i]) x_hist[i] = '0;
                foreach (y_hist[i]) y_hist[i] = '0;
                position = '0;
            end else begin
                for (int i = HIST_TAPS - 1; i > 0; i--) begin
                    x_hist[i] = x_hist[i-1];
                    y_hist[i] = y_hist[i-1];
                end
                x_hist[0] = x;
                y_hist[0] = y[OUT_W-1:0];
                position  = position + 1'b1;
            end
            r.filtered = y[OUT_W-1:0];
            r.beam_end = last;
            return r;
        endfunction

        function void note_word(logic [REQ_W-1:0] req, logic [COEF_IDX_W-1:0] idx,
                                logic signed [COEF_W-1:0] val,
                                logic signed [SAMPLE_W-1:0] smp);
            case (req)
                REQ_SAMPLE:  pending_outputs.insert(pending_outputs.size(), filter_sample(smp));
                REQ_LOAD_FF: if (idx < FF_TAPS) ff_coef[idx] = val;
                REQ_LOAD_FB: if (idx >= 1 && idx <= HIST_TAPS) fb_coef[idx-1] = val;
                default: ;
            endcase
        endfunction

        function void check_word(logic [OUT_W-1:0] got_filtered, logic got_last);
            t_filt_result exp_r;
            if (pending_outputs.size() == 0) begin
                $display("%0t: output word with none expected: filtered=%h beam_end=%b",
                         $time, got_filtered, got_last);
                errors++;
                return;
            end
            exp_r = pending_outputs.pop_front();
            if (exp_r.filtered !== got_filtered) begin
                $display("%0t: filtered mismatch: expected %h actual %h",
                         $time, exp_r.filtered, got_filtered);
                errors++;
            end
            if (exp_r.beam_end !== got_last) begin
                $display("%0t: beam_end mismatch: expected %b actual %b",
                         $time, exp_r.beam_end, got_last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [4:0] coef_index, [36:5] coef_value,
                                                 // [52:37] sample, [55:53] zero
    logic [REQ_W-1:0]      s_axis_tuser  = '0;   // [1:0] req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // [31:0] filtered
    logic                  m_axis_tlast;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    beam_filter_scoreboard filter_sb = new();
    bit gaps_on     = 1'b1;
    int words_sent  = 0;
    int idle_cycles = 0;

    iir_bandpass_beam_filter_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // output side: random back-pressure and result checking
    always @(posedge i_clk) begin
        m_axis_tready <= gaps_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            filter_sb.check_word(m_axis_tdata, m_axis_tlast);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL iir_bandpass_beam_filter_top");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input logic [REQ_W-1:0] req, input logic [COEF_IDX_W-1:0] idx,
                             input logic [COEF_W-1:0] val, input logic [SAMPLE_W-1:0] smp);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {{(IN_DATA_W - COEF_IDX_W - COEF_W - SAMPLE_W){1'b0}}, smp, val, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        filter_sb.note_word(req, idx, val, smp);
        if (req != REQ_UNUSED) words_sent++;
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        send_word(REQ_SAMPLE, COEF_IDX_W'($urandom), $urandom, smp);
    endtask

    // registers change only with the datapath quiet
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        s_axis_tvalid <= 1'b0;
        while (filter_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        filter_sb.set_register(idx, data);
    endtask

    function automatic logic [COEF_W-1:0] rand_coef(int span);
        int v;
        v = $urandom_range(0, 2 * span);
        return COEF_W'(v - span);
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(19))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // feedback taps kept within a quarter each so the section stays stable; noisy loads use full-range values
    task automatic load_coefficients(input bit noisy);
        for (int i = 0; i < FF_TAPS; i++)
            send_word(REQ_LOAD_FF, COEF_IDX_W'(i), noisy ? $urandom : rand_coef(1 << 24),
                      rand_sample());
        for (int k = 1; k <= HIST_TAPS; k++)
            send_word(REQ_LOAD_FB, COEF_IDX_W'(k), noisy ? $urandom : rand_coef(1 << 22),
                      rand_sample());
    endtask

    initial begin
        int phase;
        int pick;
        logic [CFG_DATA_W-1:0] gain_val;
        logic [CFG_DATA_W-1:0] len_val;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings, empty tables
        send_sample(16'h7FFF);
        // extreme taps, and loads that land outside the tables
        send_word(REQ_LOAD_FF, 5'd0, 32'h7FFF_FFFF, 16'h0000);
        send_word(REQ_LOAD_FF, 5'd4, 32'h8000_0000, 16'hFFFF);
        send_word(REQ_LOAD_FF, 5'd5, 32'h1234_5678, 16'h0000);
        send_word(REQ_LOAD_FF, 5'd31, 32'hFFFF_FFFF, 16'h0000);
        send_word(REQ_LOAD_FB, 5'd0, 32'h7FFF_FFFF, 16'h0000);
        send_word(REQ_LOAD_FB, 5'd1, 32'h8000_0000, 16'h0000);
        send_word(REQ_LOAD_FB, 5'd4, 32'h7FFF_FFFF, 16'h0000);
        send_word(REQ_LOAD_FB, 5'd5, 32'h0100_0000, 16'h0000);
        send_word(REQ_UNUSED, 5'd2, 32'h0100_0000, 16'h4000);
        // these saturate both ways
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
        send_sample(16'h0000);
        send_sample(16'd12345);
        write_register(CFG_SCALE_GAIN, 32'h0000_0000);
        send_sample(16'h7FFF);
        // beam length dropped below the current position ends the beam at once
        write_register(CFG_BEAM_LENGTH, 32'd3);
        send_sample(16'h1111);
        send_sample(16'hEEEE);
        write_register(CFG_SCALE_GAIN, 32'hFFFF_FFFF);

        phase = 0;
        while (words_sent < TARGET_WORDS) begin
            // one stretch of phases runs with both sides never idling
            gaps_on = !(phase >= 6 && phase < 10);
            case (phase)
                0: begin gain_val = 32'hFFFF_FFFF; len_val = 32'd0; end
                1: begin gain_val = 32'h0000_0000; len_val = 32'd65535; end
                2: begin gain_val = $urandom; len_val = 32'd1; end
                default: begin
                    pick = $urandom_range(19);
                    gain_val = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
                    pick = $urandom_range(19);
                    len_val = (pick == 0) ? 32'd65535 : (pick == 1) ? 32'd1 :
                              CFG_DATA_W'($urandom_range(2, 48));
                end
            endcase
            write_register(CFG_SCALE_GAIN, gain_val);
            write_register(CFG_BEAM_LENGTH, len_val);
            load_coefficients(phase % 5 == 4);
            repeat ($urandom_range(20, 120)) begin
                pick = $urandom_range(99);
                if (pick < 3)
                    send_word(REQ_LOAD_FF, COEF_IDX_W'($urandom), rand_coef(1 << 24),
                              rand_sample());
                else if (pick < 5)
                    send_word(REQ_LOAD_FB, COEF_IDX_W'($urandom), rand_coef(1 << 22),
                              rand_sample());
                else if (pick < 6)
                    send_word(REQ_UNUSED, COEF_IDX_W'($urandom), $urandom, rand_sample());
                else
                    send_sample(rand_sample());
            end
            phase++;
        end

        s_axis_tvalid <= 1'b0;
        while (filter_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (filter_sb.errors == 0 && filter_sb.pending() == 0) begin
            $display("PASS iir_bandpass_beam_filter_top");
        end else begin
            $display("FAIL iir_bandpass_beam_filter_top");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/iirbp_pkg.sv
rtl/iirbp_ctrl.sv
rtl/iirbp_datapath.sv
rtl/iir_bandpass_beam_filter_top.sv
dv/testbench.sv
